// ----- hw/rtl/bdclp_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package bdclp_pkg;

    // Configuration register map (word index; byte address is 4 * index).
    localparam int unsigned CFG_ADDR_W = 5;
    localparam int unsigned CFG_IDX_W  = 3;

    localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE_TICKS   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_UP_HOLD_TICKS    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_DOWN_HOLD_TICKS  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_OK_HOLD_TICKS    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_PRESS_CLICK_MASK = 3'd4;

    // Field widths.
    localparam int unsigned TICK_W    = 32;
    localparam int unsigned CFG_TKS_W = 16;
    localparam int unsigned MASK_W    = 3;

    // Register reset values.
    localparam logic [CFG_TKS_W-1:0] RST_DEBOUNCE_TICKS   = 16'd40;
    localparam logic [CFG_TKS_W-1:0] RST_UP_HOLD_TICKS    = 16'd1200;
    localparam logic [CFG_TKS_W-1:0] RST_DOWN_HOLD_TICKS  = 16'd3000;
    localparam logic [CFG_TKS_W-1:0] RST_OK_HOLD_TICKS    = 16'd1500;
    localparam logic [MASK_W-1:0]    RST_PRESS_CLICK_MASK = 3'd2;

    // Current register contents, as seen by the datapath.
    typedef struct packed {
        logic [CFG_TKS_W-1:0] debounce_ticks;
        logic [CFG_TKS_W-1:0] up_hold_ticks;
        logic [CFG_TKS_W-1:0] down_hold_ticks;
        logic [CFG_TKS_W-1:0] ok_hold_ticks;
        logic [MASK_W-1:0]    press_click_mask;
    } t_cfg;

endpackage

`default_nettype wire

// ----- hw/rtl/bdclp_cfg_regs.sv -----
`timescale 1ns / 1ps
`default_nettype none

module bdclp_cfg_regs
    import bdclp_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [CFG_ADDR_W-1:0] paddr,
    input  wire logic [31:0]           pwdata,
    output logic      [31:0]           prdata,
    output logic                       pready,
    output t_cfg                       o_cfg
);

    t_cfg                 r_cfg;
    logic                 wr_en;
    logic [CFG_IDX_W-1:0] reg_idx;

    assign pready  = 1'b1;
    assign reg_idx = paddr[CFG_ADDR_W-1:2];
    assign wr_en   = psel && penable && pwrite;
    assign o_cfg   = r_cfg;

    // Register writes; an index past the last register is dropped.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.debounce_ticks   <= RST_DEBOUNCE_TICKS;
            r_cfg.up_hold_ticks    <= RST_UP_HOLD_TICKS;
            r_cfg.down_hold_ticks  <= RST_DOWN_HOLD_TICKS;
            r_cfg.ok_hold_ticks    <= RST_OK_HOLD_TICKS;
            r_cfg.press_click_mask <= RST_PRESS_CLICK_MASK;
        end else if (wr_en) begin
            case (reg_idx)
                REG_DEBOUNCE_TICKS:   r_cfg.debounce_ticks   <= pwdata[CFG_TKS_W-1:0];
                REG_UP_HOLD_TICKS:    r_cfg.up_hold_ticks    <= pwdata[CFG_TKS_W-1:0];
                REG_DOWN_HOLD_TICKS:  r_cfg.down_hold_ticks  <= pwdata[CFG_TKS_W-1:0];
                REG_OK_HOLD_TICKS:    r_cfg.ok_hold_ticks    <= pwdata[CFG_TKS_W-1:0];
                REG_PRESS_CLICK_MASK: r_cfg.press_click_mask <= pwdata[MASK_W-1:0];
                default: ;
            endcase
        end
    end

    // Read data mux.
    always_comb begin
        case (reg_idx)
            REG_DEBOUNCE_TICKS:   prdata = {16'd0, r_cfg.debounce_ticks};
            REG_UP_HOLD_TICKS:    prdata = {16'd0, r_cfg.up_hold_ticks};
            REG_DOWN_HOLD_TICKS:  prdata = {16'd0, r_cfg.down_hold_ticks};
            REG_OK_HOLD_TICKS:    prdata = {16'd0, r_cfg.ok_hold_ticks};
            REG_PRESS_CLICK_MASK: prdata = {29'd0, r_cfg.press_click_mask};
            default:              prdata = 32'd0;
        endcase
    end

endmodule

`default_nettype wire

// ----- hw/rtl/bdclp_button.sv -----
`timescale 1ns / 1ps
`default_nettype none

module bdclp_button
    import bdclp_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_en,
    input  wire logic                 i_started,
    input  wire logic                 i_level,
    input  wire logic [TICK_W-1:0]    i_now,
    input  wire logic [CFG_TKS_W-1:0] i_debounce,
    input  wire logic [CFG_TKS_W-1:0] i_hold_thr,
    input  wire logic                 i_has_thr,
    input  wire logic                 i_on_press,
    output logic                      o_click,
    output logic                      o_hold
);

    logic              r_stable;
    logic              r_last;
    logic [TICK_W-1:0] r_sample_time;
    logic [TICK_W-1:0] r_press_time;
    logic              r_armed;
    logic              r_hold_rep;

    logic              n_stable;
    logic              n_last;
    logic [TICK_W-1:0] n_sample_time;
    logic [TICK_W-1:0] n_press_time;
    logic              n_armed;
    logic              n_hold_rep;

    logic [TICK_W-1:0] since_sample;
    logic [TICK_W-1:0] since_press;
    logic              accept;

    // Per-poll update of one button: sample tracking, debounce, click and long press.
    always_comb begin
        n_stable      = r_stable;
        n_last        = i_level;
        n_sample_time = (i_level != r_last) ? i_now : r_sample_time;
        n_press_time  = r_press_time;
        n_armed       = r_armed;
        n_hold_rep    = r_hold_rep;
        o_click       = 1'b0;
        o_hold        = 1'b0;
        since_sample  = i_now - n_sample_time;
        accept        = (i_level != r_stable) &&
                        (since_sample >= {{(TICK_W-CFG_TKS_W){1'b0}}, i_debounce});
        since_press   = '0;

        if (!i_started) begin
            // First poll only loads the levels.
            n_stable      = i_level;
            n_sample_time = i_now;
            n_armed       = i_level;
        end else begin
            if (accept) begin
                n_stable = i_level;
                if (!i_level) begin
                    if (r_armed) begin
                        n_press_time = i_now;
                        n_hold_rep   = 1'b0;
                        o_click      = i_on_press;
                    end
                end else if (!r_armed) begin
                    n_armed = 1'b1;
                end else if (!r_hold_rep && !i_on_press) begin
                    o_click = 1'b1;
                end
            end

            since_press = i_now - n_press_time;
            if (n_armed && !n_stable && !n_hold_rep && i_has_thr &&
                (since_press >= {{(TICK_W-CFG_TKS_W){1'b0}}, i_hold_thr})) begin
                n_hold_rep = 1'b1;
                o_hold     = 1'b1;
            end
        end
    end

    // Button state, advanced once per accepted poll.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stable      <= 1'b1;
            r_last        <= 1'b1;
            r_sample_time <= '0;
            r_press_time  <= '0;
            r_armed       <= 1'b0;
            r_hold_rep    <= 1'b0;
        end else if (i_en) begin
            r_stable      <= n_stable;
            r_last        <= n_last;
            r_sample_time <= n_sample_time;
            r_press_time  <= n_press_time;
            r_armed       <= n_armed;
            r_hold_rep    <= n_hold_rep;
        end
    end

endmodule

`default_nettype wire

// ----- hw/rtl/button_debounce_click_longpress.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Debouncer with click and long-press detection for up to three active-low
// buttons. Each input transaction is one poll: the raw pin levels and the
// current free-running tick count. Each poll yields exactly one result
// transaction with a click mask and a long-press mask; the first poll after
// reset only loads the levels and reports nothing. The block takes one poll
// per clock cycle while the result channel accepts results; each poll passes
// through the input register and then the result register. Each button is
// handled by its own unit, whose state advances as a poll leaves the input
// register. Settling and hold times are set through the APB registers at byte
// addresses 0x00 (debounce), 0x04/0x08/0x0C (up/down/ok hold) and 0x10
// (click-on-press mask); write them only while no poll is in flight.
module button_debounce_click_longpress
    import bdclp_pkg::*;
#(
    parameter int unsigned NUM_BUTTONS = 3
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    // Poll channel
    input  wire logic                  i_in_valid,
    output logic                       o_in_ready,
    input  wire logic [MASK_W-1:0]     i_button_levels,
    input  wire logic [TICK_W-1:0]     i_now_ticks,
    // Result channel
    output logic                       o_out_valid,
    input  wire logic                  i_out_ready,
    output logic      [MASK_W-1:0]     o_click_mask,
    output logic      [MASK_W-1:0]     o_hold_mask,
    // Configuration port
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [CFG_ADDR_W-1:0] paddr,
    input  wire logic [31:0]           pwdata,
    output logic      [31:0]           prdata,
    output logic                       pready
);

    t_cfg              cfg;

    logic              r_in_valid;
    logic [MASK_W-1:0] r_levels;
    logic [TICK_W-1:0] r_now;
    logic              r_started;
    logic              r_out_valid;
    logic [MASK_W-1:0] r_click_mask;
    logic [MASK_W-1:0] r_hold_mask;

    logic              advance;
    logic [NUM_BUTTONS-1:0] btn_click;
    logic [NUM_BUTTONS-1:0] btn_hold;
    logic [MASK_W-1:0] n_click_mask;
    logic [MASK_W-1:0] n_hold_mask;

    bdclp_cfg_regs u_cfg_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    // A poll moves from the input register to the result register when the
    // result register is empty or its transaction completes this cycle.
    assign advance     = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready  = !r_in_valid || advance;
    assign o_out_valid = r_out_valid;
    assign o_click_mask = r_click_mask;
    assign o_hold_mask  = r_hold_mask;

    // Per-button units; buttons past the third read as released and have no
    // long-press threshold.
    for (genvar i = 0; i < NUM_BUTTONS; i++) begin : g_btn
        logic                 lvl;
        logic [CFG_TKS_W-1:0] thr;
        logic                 has_thr;
        logic                 on_press;

        if (i == 0) begin : g_up
            assign lvl      = r_levels[0];
            assign thr      = cfg.up_hold_ticks;
            assign has_thr  = 1'b1;
            assign on_press = cfg.press_click_mask[0];
        end else if (i == 1) begin : g_down
            assign lvl      = r_levels[1];
            assign thr      = cfg.down_hold_ticks;
            assign has_thr  = 1'b1;
            assign on_press = cfg.press_click_mask[1];
        end else if (i == 2) begin : g_ok
            assign lvl      = r_levels[2];
            assign thr      = cfg.ok_hold_ticks;
            assign has_thr  = 1'b1;
            assign on_press = cfg.press_click_mask[2];
        end else begin : g_extra
            assign lvl      = 1'b1;
            assign thr      = '0;
            assign has_thr  = 1'b0;
            assign on_press = 1'b0;
        end

        bdclp_button u_button (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_en       (advance),
            .i_started  (r_started),
            .i_level    (lvl),
            .i_now      (r_now),
            .i_debounce (cfg.debounce_ticks),
            .i_hold_thr (thr),
            .i_has_thr  (has_thr),
            .i_on_press (on_press),
            .o_click    (btn_click[i]),
            .o_hold     (btn_hold[i])
        );
    end

    // Only the first three buttons reach the result masks.
    for (genvar j = 0; j < MASK_W; j++) begin : g_mask
        if (j < NUM_BUTTONS) begin : g_used
            assign n_click_mask[j] = btn_click[j];
            assign n_hold_mask[j]  = btn_hold[j];
        end else begin : g_unused
            assign n_click_mask[j] = 1'b0;
            assign n_hold_mask[j]  = 1'b0;
        end
    end

    // Input register control.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
            r_started  <= 1'b0;
        end else begin
            if (o_in_ready) begin
                r_in_valid <= i_in_valid;
            end
            if (advance) begin
                r_started <= 1'b1;
            end
        end
    end

    // Input register payload.
    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_levels <= i_button_levels;
            r_now    <= i_now_ticks;
        end
    end

    // Result register control.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // Result register payload.
    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_click_mask <= n_click_mask;
            r_hold_mask  <= n_hold_mask;
        end
    end

endmodule

`default_nettype wire

// ----- tb/sv/bdclp_result_monitor.sv -----
`timescale 1ns / 1ps

// Watches the poll, result and register channels of the debouncer. It keeps its
// own copy of the registers and of the per-button state, predicts one result per
// accepted poll, and compares every accepted result with the oldest prediction.
module bdclp_result_monitor
    import bdclp_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_in_valid,
    input  wire logic                  i_in_ready,
    input  wire logic [MASK_W-1:0]     i_button_levels,
    input  wire logic [TICK_W-1:0]     i_now_ticks,
    input  wire logic                  i_out_valid,
    input  wire logic                  i_out_ready,
    input  wire logic [MASK_W-1:0]     i_click_mask,
    input  wire logic [MASK_W-1:0]     i_hold_mask,
    input  wire logic                  i_psel,
    input  wire logic                  i_penable,
    input  wire logic                  i_pwrite,
    input  wire logic [CFG_ADDR_W-1:0] i_paddr,
    input  wire logic [31:0]           i_pwdata,
    input  wire logic [31:0]           i_prdata,
    input  wire logic                  i_pready,
    output int unsigned                o_fail_count,
    output int unsigned                o_pending
);

    localparam int unsigned NUM_BTN      = 3;
    localparam int unsigned REPORT_LIMIT = 10;

    typedef struct packed {
        logic [MASK_W-1:0] clicks;
        logic [MASK_W-1:0] holds;
    } t_poll_result;

    // Predicted results, oldest first.
    t_poll_result expected_q[$];

    // Register copies.
    logic [CFG_TKS_W-1:0] settle_ticks;
    logic [CFG_TKS_W-1:0] hold_ticks [NUM_BTN];
    logic [MASK_W-1:0]    click_on_press;

    // Per-button debounce state.
    logic                 seen_first;
    logic [NUM_BTN-1:0]   stable_lvl;
    logic [NUM_BTN-1:0]   last_lvl;
    logic [NUM_BTN-1:0]   armed;
    logic [NUM_BTN-1:0]   hold_done;
    logic [TICK_W-1:0]    sample_at   [NUM_BTN];
    logic [TICK_W-1:0]    press_start [NUM_BTN];

    int unsigned          polls_seen;
    int unsigned          results_seen;

    // Return registers and button state to their values after reset.
    task automatic clear_state();
        settle_ticks   = RST_DEBOUNCE_TICKS;
        hold_ticks[0]  = RST_UP_HOLD_TICKS;
        hold_ticks[1]  = RST_DOWN_HOLD_TICKS;
        hold_ticks[2]  = RST_OK_HOLD_TICKS;
        click_on_press = RST_PRESS_CLICK_MASK;
        seen_first     = 1'b0;
        stable_lvl     = '1;
        last_lvl       = '1;
        armed          = '0;
        hold_done      = '0;
        for (int b = 0; b < NUM_BTN; b++) begin
            sample_at[b]   = '0;
            press_start[b] = '0;
        end
    endtask

    // Advance every button by one poll and return the clicks and long presses it causes.
    task automatic advance_buttons(input logic [MASK_W-1:0] levels,
                                   input logic [TICK_W-1:0] now,
                                   output t_poll_result res);
        logic [TICK_W-1:0] elapsed;
        res = '0;
        if (!seen_first) begin
            // The first poll only loads the levels; a button held here stays unarmed.
            seen_first = 1'b1;
            stable_lvl = levels;
            last_lvl   = levels;
            armed      = levels;
            for (int b = 0; b < NUM_BTN; b++) begin
                sample_at[b] = now;
            end
        end else begin
            for (int b = 0; b < NUM_BTN; b++) begin
                if (levels[b] != last_lvl[b]) begin
                    last_lvl[b]  = levels[b];
                    sample_at[b] = now;
                end

                // A changed level is taken once it has stayed long enough.
                elapsed = now - sample_at[b];
                if (levels[b] != stable_lvl[b] && elapsed >= TICK_W'(settle_ticks)) begin
                    stable_lvl[b] = levels[b];
                    if (!levels[b]) begin
                        if (armed[b]) begin
                            press_start[b] = now;
                            hold_done[b]   = 1'b0;
                            if (click_on_press[b]) begin
                                res.clicks[b] = 1'b1;
                            end
                        end
                    end else if (!armed[b]) begin
                        armed[b] = 1'b1;
                    end else if (!hold_done[b] && !click_on_press[b]) begin
                        res.clicks[b] = 1'b1;
                    end
                end

                // A long press is reported once per press.
                elapsed = now - press_start[b];
                if (armed[b] && !stable_lvl[b] && !hold_done[b] &&
                    elapsed >= TICK_W'(hold_ticks[b])) begin
                    hold_done[b] = 1'b1;
                    res.holds[b] = 1'b1;
                end
            end
        end
    endtask

    always @(posedge i_clk) begin : watch_channels
        t_poll_result          want;
        logic [31:0]           reg_value;
        logic                  reg_known;
        logic [CFG_IDX_W-1:0]  reg_idx;
        reg_idx = i_paddr[CFG_ADDR_W-1:2];
        if (!i_rst_n) begin
            clear_state();
            expected_q.delete();
            o_fail_count = 0;
            polls_seen   = 0;
            results_seen = 0;
        end else begin
            // Compare a completed result transaction with the oldest prediction.
            if (i_out_valid && i_out_ready) begin
                results_seen++;
                if (expected_q.size() == 0) begin
                    o_fail_count++;
                    if (o_fail_count <= REPORT_LIMIT) begin
                        $display("ERROR: result %0d arrived with no poll outstanding",
                                 results_seen);
                    end
                end else begin
                    want = expected_q.pop_front();
                    if (want.clicks !== i_click_mask || want.holds !== i_hold_mask) begin
                        o_fail_count++;
                        if (o_fail_count <= REPORT_LIMIT) begin
                            $display("ERROR: result %0d: click exp %b got %b, hold exp %b got %b",
                                     results_seen, want.clicks, i_click_mask,
                                     want.holds, i_hold_mask);
                        end
                    end
                end
            end

            // Every accepted poll yields exactly one result.
            if (i_in_valid && i_in_ready) begin
                polls_seen++;
                advance_buttons(i_button_levels, i_now_ticks, want);
                expected_q.push_back(want);
            end

            // Register writes; an index past the map is ignored.
            if (i_psel && i_penable && i_pwrite && i_pready) begin
                case (reg_idx)
                    REG_DEBOUNCE_TICKS:   settle_ticks   = i_pwdata[CFG_TKS_W-1:0];
                    REG_UP_HOLD_TICKS:    hold_ticks[0]  = i_pwdata[CFG_TKS_W-1:0];
                    REG_DOWN_HOLD_TICKS:  hold_ticks[1]  = i_pwdata[CFG_TKS_W-1:0];
                    REG_OK_HOLD_TICKS:    hold_ticks[2]  = i_pwdata[CFG_TKS_W-1:0];
                    REG_PRESS_CLICK_MASK: click_on_press = i_pwdata[MASK_W-1:0];
                    default: ;
                endcase
            end

            // Register reads return the current contents.
            if (i_psel && i_penable && !i_pwrite && i_pready) begin
                reg_known = 1'b1;
                reg_value = '0;
                case (reg_idx)
                    REG_DEBOUNCE_TICKS:   reg_value[CFG_TKS_W-1:0] = settle_ticks;
                    REG_UP_HOLD_TICKS:    reg_value[CFG_TKS_W-1:0] = hold_ticks[0];
                    REG_DOWN_HOLD_TICKS:  reg_value[CFG_TKS_W-1:0] = hold_ticks[1];
                    REG_OK_HOLD_TICKS:    reg_value[CFG_TKS_W-1:0] = hold_ticks[2];
                    REG_PRESS_CLICK_MASK: reg_value[MASK_W-1:0]    = click_on_press;
                    default:              reg_known = 1'b0;
                endcase
                if (reg_known && i_prdata !== reg_value) begin
                    o_fail_count++;
                    if (o_fail_count <= REPORT_LIMIT) begin
                        $display("ERROR: register %0d read exp %h got %h",
                                 reg_idx, reg_value, i_prdata);
                    end
                end
            end
        end
        o_pending = expected_q.size();
    end

endmodule

// ----- tb/sv/testbench.sv -----
`timescale 1ns / 1ps

module testbench;
    import bdclp_pkg::*;

    localparam int unsigned IDLE_LIMIT      = 3000;
    localparam int unsigned PHASES          = 9;
    localparam int unsigned POLLS_PER_PHASE = 170;
    localparam int unsigned MAX_GAP         = 18;
    localparam int unsigned HOLDOFF_AT      = 700;
    localparam int unsigned HOLDOFF_CYCLES  = 300;
    localparam int unsigned DRAIN_CYCLES    = 8;

    localparam logic [CFG_IDX_W-1:0] REG_PAST_LAST = REG_PRESS_CLICK_MASK + 1'b1;

    logic                  clk          = 1'b0;
    logic                  rst_n        = 1'b0;
    logic                  poll_valid   = 1'b0;
    logic                  poll_ready;
    logic [MASK_W-1:0]     poll_levels  = '1;
    logic [TICK_W-1:0]     poll_now     = '0;
    logic                  result_valid;
    logic                  result_ready = 1'b0;
    logic [MASK_W-1:0]     click_mask;
    logic [MASK_W-1:0]     hold_mask;
    logic                  psel         = 1'b0;
    logic                  penable      = 1'b0;
    logic                  pwrite       = 1'b0;
    logic [CFG_ADDR_W-1:0] paddr        = '0;
    logic [31:0]           pwdata       = '0;
    logic [31:0]           prdata;
    logic                  pready;

    int unsigned           fail_count;
    int unsigned           pending;
    int unsigned           results_taken = 0;
    int unsigned           quiet_cycles  = 0;

    // Stimulus shaping, changed per phase.
    logic                  sender_gapless = 1'b0;
    int unsigned           step_max       = 8;
    logic [TICK_W-1:0]     tick_now       = '0;
    logic [MASK_W-1:0]     intent         = '1;

    always #5 clk = ~clk;

    button_debounce_click_longpress dut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_in_valid      (poll_valid),
        .o_in_ready      (poll_ready),
        .i_button_levels (poll_levels),
        .i_now_ticks     (poll_now),
        .o_out_valid     (result_valid),
        .i_out_ready     (result_ready),
        .o_click_mask    (click_mask),
        .o_hold_mask     (hold_mask),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready)
    );

    bdclp_result_monitor monitor (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_in_valid      (poll_valid),
        .i_in_ready      (poll_ready),
        .i_button_levels (poll_levels),
        .i_now_ticks     (poll_now),
        .i_out_valid     (result_valid),
        .i_out_ready     (result_ready),
        .i_click_mask    (click_mask),
        .i_hold_mask     (hold_mask),
        .i_psel          (psel),
        .i_penable       (penable),
        .i_pwrite        (pwrite),
        .i_paddr         (paddr),
        .i_pwdata        (pwdata),
        .i_prdata        (prdata),
        .i_pready        (pready),
        .o_fail_count    (fail_count),
        .o_pending       (pending)
    );

    // Offer one poll after a random gap and hold it until the transaction completes.
    task automatic send_poll(input logic [MASK_W-1:0] levels, input logic [TICK_W-1:0] now);
        int unsigned gap;
        gap = sender_gapless ? 0 : $urandom_range(0, MAX_GAP);
        if (gap != 0) begin
            poll_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        poll_valid  <= 1'b1;
        poll_levels <= levels;
        poll_now    <= now;
        do @(posedge clk); while (!poll_ready);
        @(negedge clk);
    endtask

    // Stop offering polls and let every outstanding result come back.
    task automatic wait_idle();
        poll_valid <= 1'b0;
        while (pending != 0) @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    // One register transaction: setup cycle, then access cycle, then back to idle.
    task automatic apb_access(input logic is_write, input logic [CFG_IDX_W-1:0] idx,
                              input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= is_write;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(negedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(negedge clk);
    endtask

    // Program all registers, read them back and scale the tick steps to match.
    task automatic apply_settings(input logic [CFG_TKS_W-1:0] settle,
                                  input logic [CFG_TKS_W-1:0] up_hold,
                                  input logic [CFG_TKS_W-1:0] down_hold,
                                  input logic [CFG_TKS_W-1:0] ok_hold,
                                  input logic [MASK_W-1:0]    on_press);
        logic [CFG_TKS_W-1:0] longest;
        apb_access(1'b1, REG_DEBOUNCE_TICKS,   {16'd0, settle});
        apb_access(1'b1, REG_UP_HOLD_TICKS,    {16'd0, up_hold});
        apb_access(1'b1, REG_DOWN_HOLD_TICKS,  {16'd0, down_hold});
        apb_access(1'b1, REG_OK_HOLD_TICKS,    {16'd0, ok_hold});
        apb_access(1'b1, REG_PRESS_CLICK_MASK, {29'd0, on_press});
        apb_access(1'b0, REG_DEBOUNCE_TICKS,   '0);
        apb_access(1'b0, REG_UP_HOLD_TICKS,    '0);
        apb_access(1'b0, REG_DOWN_HOLD_TICKS,  '0);
        apb_access(1'b0, REG_OK_HOLD_TICKS,    '0);
        apb_access(1'b0, REG_PRESS_CLICK_MASK, '0);
        longest = up_hold;
        if (down_hold > longest) longest = down_hold;
        if (ok_hold > longest) longest = ok_hold;
        step_max = (32'(settle) + 32'(longest)) / 4 + 2;
    endtask

    // A poll from a slowly changing button pattern, with glitches and stray jumps.
    task automatic random_poll();
        logic [MASK_W-1:0] levels;
        int unsigned       roll;
        roll = $urandom_range(0, 99);
        if (roll < 2) begin
            tick_now = $urandom();
        end else if (roll >= 5) begin
            tick_now = tick_now + $urandom_range(0, step_max);
        end
        for (int b = 0; b < MASK_W; b++) begin
            if ($urandom_range(0, 9) == 0) intent[b] = ~intent[b];
        end
        levels = intent;
        for (int b = 0; b < MASK_W; b++) begin
            if ($urandom_range(0, 15) == 0) levels[b] = ~levels[b];
        end
        if ($urandom_range(0, 49) == 0) levels = MASK_W'($urandom_range(0, 7));
        send_poll(levels, tick_now);
    endtask

    // Count cycles in which no transaction completes on either data channel.
    always @(posedge clk) begin
        if (!rst_n || (poll_valid && poll_ready) || (result_valid && result_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin : watchdog
        wait (quiet_cycles >= IDLE_LIMIT);
        $display("Mismatches found");
        $finish;
    end

    // Result side: random stalls, gapless stretches and one long hold-off.
    initial begin : result_sink
        int unsigned stall;
        wait (rst_n);
        @(negedge clk);
        forever begin
            if (results_taken == HOLDOFF_AT) begin
                result_ready <= 1'b0;
                repeat (HOLDOFF_CYCLES) @(negedge clk);
            end
            stall = ((results_taken / 150) % 3 == 2) ? 0 : $urandom_range(0, MAX_GAP);
            if (stall != 0) begin
                result_ready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            result_ready <= 1'b1;
            do @(posedge clk); while (!result_valid);
            results_taken++;
            @(negedge clk);
        end
    end

    initial begin : stimulus
        logic [TICK_W-1:0]    t;
        logic [CFG_TKS_W-1:0] settle;
        int unsigned          roll;
        repeat (7) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Reset settings, with settling and hold thresholds hit exactly and the
        // tick counter wrapping early on.
        t = 32'hFFFF_FFE0;
        send_poll(3'b011, t);          // first poll; ok is held, so it starts unarmed
        send_poll(3'b111, t + 5);
        send_poll(3'b111, t + 44);     // one tick short of settling
        send_poll(3'b111, t + 45);     // settles across the wrap and arms ok
        send_poll(3'b000, t + 50);
        send_poll(3'b000, t + 90);     // all pressed; down clicks on press
        send_poll(3'b000, t + 1289);   // up one tick short of its hold time
        send_poll(3'b000, t + 1290);   // up long press
        send_poll(3'b000, t + 1590);   // ok long press
        send_poll(3'b111, t + 2000);
        send_poll(3'b111, t + 2040);   // no release clicks after long presses
        send_poll(3'b101, t + 2200);
        send_poll(3'b111, t + 2210);   // bounce restarts the settling time
        send_poll(3'b101, t + 2220);
        send_poll(3'b101, t + 2260);   // down press accepted
        send_poll(3'b101, t + 5260);   // down long press
        send_poll(3'b110, t + 5270);
        send_poll(3'b110, t + 5310);
        send_poll(3'b111, t + 5320);
        send_poll(3'b111, t + 5360);   // up short press clicks on release
        wait_idle();

        // Zero settling time and the shortest holds; a write past the map is dropped.
        apply_settings(16'd0, 16'd1, 16'd1, 16'd1, 3'b000);
        apb_access(1'b1, REG_PAST_LAST, 32'hFFFF_FFFF);
        t = 32'h8000_0000;
        send_poll(3'b000, t);          // pressed on the same poll
        send_poll(3'b000, t + 1);      // every hold fires
        send_poll(3'b111, t + 1);
        send_poll(3'b010, t + 1);
        send_poll(3'b111, t + 1);      // up and ok click on release
        wait_idle();

        // Random phases, each with its own register settings.
        tick_now = t + 1;
        for (int phase = 0; phase < PHASES; phase++) begin
            sender_gapless = (phase % 3 == 1);
            if (phase == 0) begin
                apply_settings(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 3'b111);
            end else if (phase == 1) begin
                apply_settings(16'd0, 16'd1, 16'd1, 16'd1, 3'b000);
            end else begin
                roll = $urandom_range(0, 3);
                case (roll)
                    0:       settle = 16'd0;
                    1:       settle = CFG_TKS_W'($urandom_range(1, 8));
                    2:       settle = CFG_TKS_W'($urandom_range(9, 60));
                    default: settle = CFG_TKS_W'($urandom_range(61, 2000));
                endcase
                apply_settings(settle,
                               CFG_TKS_W'($urandom_range(0, 3) == 0
                                          ? $urandom_range(1, 20)
                                          : $urandom_range(21, 400)),
                               CFG_TKS_W'($urandom_range(0, 3) == 0
                                          ? $urandom_range(1, 20)
                                          : $urandom_range(21, 400)),
                               CFG_TKS_W'($urandom_range(0, 3) == 0
                                          ? $urandom_range(1, 20)
                                          : $urandom_range(21, 400)),
                               MASK_W'($urandom_range(0, 7)));
            end
            repeat (POLLS_PER_PHASE) random_poll();
            wait_idle();
        end

        if (fail_count == 0 && pending == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
